>>> rtl/huffman_code_cost_macros.svh
// Assertion macros for the Huffman code cost block.
// Used by the top level; no other dependencies.
`ifndef HUFFMAN_CODE_COST_MACROS_SVH
`define HUFFMAN_CODE_COST_MACROS_SVH

// Check a consequence in the same cycle as its antecedent
`define HCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent
`define HCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hcc_pkg.sv
// Shared widths, controller/datapath command and status types, saturating add.
// No dependencies.
`default_nettype none

package hcc_pkg;

  localparam int COUNT_W      = 32;
  localparam int WEIGHT_W     = 48;
  localparam int ALPHABET_DEF = 256;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // input word accepted
    logic scan_init;  // start a search pass over the store
    logic rd_en;      // read the next slot of the pass
    logic wr_a;       // write the merged weight to the smaller slot
    logic wr_b;       // kill the larger slot, account the merge
    logic publish;    // move totals to the output register, start afresh
  } hcc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic multi_live;  // two or more live weights remain
    logic scan_last;   // this read is the last loaded slot
    logic out_free;    // output register can take a result
  } hcc_status_t;

  // Add two weights, sticking at the all-ones value
  function automatic logic [WEIGHT_W-1:0] sat_add(input logic [WEIGHT_W-1:0] a,
                                                  input logic [WEIGHT_W-1:0] b);
    logic [WEIGHT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WEIGHT_W] ? WEIGHT_MAX : s[WEIGHT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/hcc_if.sv
// Valid/ready channel interfaces for the histogram input and the cost result.
// Depends on hcc_pkg.
`default_nettype none

interface hcc_in_if import hcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count;
  logic               last;

  modport source (output valid, output count, output last, input ready);
  modport sink   (input valid, input count, input last, output ready);
endinterface

interface hcc_out_if import hcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] total_bits;
  logic [WEIGHT_W-1:0] total_values;

  modport source (output valid, output total_bits, output total_values, input ready);
  modport sink   (input valid, input total_bits, input total_values, output ready);
endinterface

`default_nettype wire

>>> rtl/hcc_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module hcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/hcc_ctrl.sv
// Controller for the Huffman code cost block: load, search, merge, publish.
// Depends on hcc_pkg.
`default_nettype none

module hcc_ctrl import hcc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_last_i,
  output logic             in_ready_o,
  input  wire hcc_status_t status_i,
  output hcc_cmd_t         cmd_o
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_WRA   = 3'd4;
  localparam logic [2:0] ST_WRB   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status_i.multi_live) begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      // last read word is compared in this cycle
      ST_DRAIN: begin
        state_d = ST_WRA;
      end
      ST_WRA: begin
        cmd_o.wr_a = 1'b1;
        state_d    = ST_WRB;
      end
      ST_WRB: begin
        cmd_o.wr_b = 1'b1;
        state_d    = ST_EVAL;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hcc_dp.sv
// Datapath for the Huffman code cost block: weight store, two-minimum search,
// merge adder, totals and output register. Depends on hcc_pkg and hcc_ram.
`default_nettype none

module hcc_dp import hcc_pkg::*; #(
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [COUNT_W-1:0] count_i,
  input  wire hcc_cmd_t           cmd_i,
  output hcc_status_t             status_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [WEIGHT_W-1:0]     total_bits_o,
  output logic [WEIGHT_W-1:0]     total_values_o
);

  localparam int AW = $clog2(ALPHABET);
  localparam int CW = $clog2(ALPHABET + 1);
  localparam int RW = WEIGHT_W + 1;  // live flag over weight

  logic [CW-1:0]       pos_q, pos_d;
  logic [CW-1:0]       live_q, live_d;
  logic [WEIGHT_W-1:0] values_q, values_d;
  logic [WEIGHT_W-1:0] bits_q, bits_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic                rd_vld_q;
  logic [AW-1:0]       rd_slot_q;
  logic                has1_q, has1_d, has2_q, has2_d;
  logic [WEIGHT_W-1:0] m1_q, m1_d, m2_q, m2_d;
  logic [AW-1:0]       s1_q, s1_d, s2_q, s2_d;
  logic                out_valid_q;
  logic [WEIGHT_W-1:0] out_bits_q, out_values_q;

  logic                room;
  logic                cnt_nz;
  logic [WEIGHT_W-1:0] cnt_ext;
  logic [WEIGHT_W-1:0] merged;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [RW-1:0]       wdata;
  logic [RW-1:0]       rdata;
  logic                rd_live;
  logic [WEIGHT_W-1:0] rd_w;

  assign room    = pos_q < CW'(ALPHABET);
  assign cnt_nz  = count_i != '0;
  assign cnt_ext = {{(WEIGHT_W-COUNT_W){1'b0}}, count_i};
  assign merged  = sat_add(m1_q, m2_q);
  assign rd_live = rdata[WEIGHT_W];
  assign rd_w    = rdata[WEIGHT_W-1:0];

  // Store write port: load, merged weight, or dead slot
  always_comb begin
    we    = 1'b0;
    waddr = pos_q[AW-1:0];
    wdata = {cnt_nz, cnt_ext};
    if (cmd_i.load && room) begin
      we = 1'b1;
    end
    if (cmd_i.wr_a) begin
      we    = 1'b1;
      waddr = s1_q;
      wdata = {1'b1, merged};
    end
    if (cmd_i.wr_b) begin
      we    = 1'b1;
      waddr = s2_q;
      wdata = '0;
    end
  end

  hcc_ram #(
    .WIDTH (RW),
    .DEPTH (ALPHABET)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // Fill count, live count and totals
  always_comb begin
    pos_d    = pos_q;
    live_d   = live_q;
    values_d = values_q;
    bits_d   = bits_q;
    if (cmd_i.load && room) begin
      pos_d    = pos_q + CW'(1);
      values_d = sat_add(values_q, cnt_ext);
      if (cnt_nz) begin
        live_d = live_q + CW'(1);
      end
    end
    if (cmd_i.wr_b) begin
      live_d = live_q - CW'(1);
      bits_d = sat_add(bits_q, merged);
    end
    if (cmd_i.publish) begin
      pos_d    = '0;
      live_d   = '0;
      values_d = '0;
      bits_d   = '0;
    end
  end

  // Two-minimum search; strict compares keep the lower slot on ties
  always_comb begin
    idx_d  = idx_q;
    has1_d = has1_q;
    has2_d = has2_q;
    m1_d   = m1_q;
    m2_d   = m2_q;
    s1_d   = s1_q;
    s2_d   = s2_q;
    if (cmd_i.rd_en) begin
      idx_d = idx_q + AW'(1);
    end
    if (rd_vld_q && rd_live) begin
      if (!has1_q || rd_w < m1_q) begin
        has1_d = 1'b1;
        m1_d   = rd_w;
        s1_d   = rd_slot_q;
        has2_d = has1_q;
        m2_d   = m1_q;
        s2_d   = s1_q;
      end else if (!has2_q || rd_w < m2_q) begin
        has2_d = 1'b1;
        m2_d   = rd_w;
        s2_d   = rd_slot_q;
      end
    end
    if (cmd_i.scan_init) begin
      idx_d  = '0;
      has1_d = 1'b0;
      has2_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      live_q      <= '0;
      values_q    <= '0;
      bits_q      <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      has1_q      <= 1'b0;
      has2_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      live_q   <= live_d;
      values_q <= values_d;
      bits_q   <= bits_d;
      idx_q    <= idx_d;
      rd_vld_q <= cmd_i.rd_en;
      has1_q   <= has1_d;
      has2_q   <= has2_d;
      // hold the result until taken
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_slot_q <= idx_q;
    m1_q      <= m1_d;
    m2_q      <= m2_d;
    s1_q      <= s1_d;
    s2_q      <= s2_d;
    if (cmd_i.publish) begin
      out_bits_q   <= bits_q;
      out_values_q <= values_q;
    end
  end

  assign status_o.multi_live = live_q >= CW'(2);
  assign status_o.scan_last  = CW'(idx_q) == (pos_q - CW'(1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign total_bits_o   = out_bits_q;
  assign total_values_o = out_values_q;

endmodule

`default_nettype wire

>>> rtl/huffman_code_cost.sv
// Loading takes one histogram word per cycle. After the word marked last, the nonzero
// counts among the loaded words are merged in rounds until fewer than two are live; each
// round is a search pass over the store for the two least weights, then the merge writes;
// the publish step waits further while an earlier result is still held.
// Throughput: one histogram at a time; loading of the next starts as the result is held.
// Reset (rst_ni, asynchronous, active low) clears control and totals; the store itself
// is not cleared, a fill count marks the slots that hold words of this histogram.
`default_nettype none
`include "huffman_code_cost_macros.svh"

module huffman_code_cost import hcc_pkg::*; #(
  parameter int ALPHABET = ALPHABET_DEF
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  hcc_in_if.sink     in_i,
  hcc_out_if.source  out_o
);

  hcc_cmd_t    cmd;
  hcc_status_t status;

  hcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hcc_dp #(
    .ALPHABET (ALPHABET)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .count_i        (in_i.count),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .total_bits_o   (out_o.total_bits),
    .total_values_o (out_o.total_values)
  );

  // Input stays closed while the store is searched or rewritten
  `HCC_ASSERT_NOW(a_busy_closed, clk_i, rst_ni,
                  cmd.rd_en || cmd.wr_a || cmd.wr_b, !in_i.ready,
                  "input open during merge")
  // The last word closes the input for at least the next cycle
  `HCC_ASSERT_NEXT(a_last_closes, clk_i, rst_ni,
                   in_i.valid && in_i.ready && in_i.last, !in_i.ready,
                   "input open after last word")
  // A new result never overwrites one still waiting
  `HCC_ASSERT_NOW(a_publish_free, clk_i, rst_ni,
                  cmd.publish, !out_o.valid || out_o.ready,
                  "waiting result overwritten")
  // A merge write follows a full search pass and its drain cycle
  `HCC_ASSERT_NOW(a_merge_after_scan, clk_i, rst_ni,
                  cmd.wr_a, $past(status.scan_last, 2) && $past(cmd.rd_en, 2),
                  "merge without completed search")

endmodule

`default_nettype wire
